FILE: rtl/core/uart_rb_pkg.sv
// Shared constants for the serial-port receive ring buffer.
package uart_rb_pkg;

  // Default store depth; the indices wrap at this value.
  localparam int unsigned DefaultBufferDepth = 32;

  // Item field widths.
  localparam int unsigned DataW  = 8;
  localparam int unsigned CountW = 8;

  // Operation codes carried by an input item.
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Characters with special handling on receive.
  localparam logic [DataW-1:0] CHAR_NUL = 8'd0;
  localparam logic [DataW-1:0] CHAR_LF  = 8'd10;
  localparam logic [DataW-1:0] CHAR_CR  = 8'd13;

endpackage

FILE: rtl/core/uart_rb_if.sv
// Valid/ready channel interfaces for request and response items.
interface uart_rb_req_if
  import uart_rb_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [DataW-1:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface uart_rb_rsp_if
  import uart_rb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  read_data;
  logic              was_empty;
  logic              overflow_flush;
  logic [CountW-1:0] line_end_count;

  modport source (output valid, output read_data, output was_empty,
                  output overflow_flush, output line_end_count, input ready);
  modport sink   (input valid, input read_data, input was_empty,
                  input overflow_flush, input line_end_count, output ready);
endinterface

FILE: rtl/core/uart_rx_line_ring_buffer.sv
// Top level: serial-port receive ring buffer with line-end counting.
//
// Request channel req_i carries one item: a byte received from the line
// (operation = receive) or a request to pop one byte (operation = read).
// Response channel rsp_o returns exactly one item per request: the popped
// byte, an empty flag, an overflow-flush flag and the carriage-return count.
// The store holds BUFFER_DEPTH-1 bytes; a receive into a full buffer flushes
// it and drops the byte. NUL is ignored and LF is not stored.
// A receive or an empty read answers in the cycle after acceptance. A read
// that pops a byte answers through the registered read port of the byte
// store and then the ST_READ state, which loads the output register. One
// item is in flight at a time.
// The response sits in an output register; a new request is taken while
// that register is being emptied in the same cycle. If the receiver stalls,
// the response holds and req_i.ready stays low until it is taken.
// Reset clears head, tail, the counter and the control state at once; the
// byte store is not cleared, and no read can reach an unwritten entry.
module uart_rx_line_ring_buffer
  import uart_rb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DefaultBufferDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  uart_rb_req_if.sink        req_i,
  uart_rb_rsp_if.source      rsp_o
);

  localparam int unsigned IdxW = $clog2(BUFFER_DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(BUFFER_DEPTH - 1);

  // Sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_q, state_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [IdxW-1:0]   tail_q, tail_d;
  logic [CountW-1:0] cr_cnt_q, cr_cnt_d;

  logic              rsp_valid_q, rsp_valid_d;
  logic [DataW-1:0]  rsp_data_q, rsp_data_d;
  logic              rsp_empty_q, rsp_empty_d;
  logic              rsp_flush_q, rsp_flush_d;
  logic [CountW-1:0] rsp_count_q, rsp_count_d;

  logic [DataW-1:0]  mem_q [BUFFER_DEPTH];
  logic [DataW-1:0]  mem_rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr;

  logic [IdxW-1:0]   head_nxt, tail_nxt;
  logic              accept;

  // Wrapping index increments
  assign head_nxt = (head_q == IdxLast) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == IdxLast) ? '0 : tail_q + 1'b1;

  // Take a request when idle and the output register is free next cycle
  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Request decode, pointer updates and response staging
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cr_cnt_d    = cr_cnt_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = head_nxt;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_data_d  = rsp_data_q;
    rsp_empty_d = rsp_empty_q;
    rsp_flush_d = rsp_flush_q;
    rsp_count_d = rsp_count_q;

    if (state_q == ST_READ) begin
      // store data arrives now
      state_d     = ST_IDLE;
      rsp_valid_d = 1'b1;
      rsp_data_d  = mem_rdata_q;
      rsp_empty_d = 1'b0;
      rsp_flush_d = 1'b0;
      rsp_count_d = cr_cnt_q;
    end else if (accept) begin
      unique case (req_i.operation)
        OP_RECEIVE: begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = '0;
          rsp_empty_d = 1'b0;
          rsp_flush_d = 1'b0;
          if (head_nxt == tail_q) begin
            // full: flush everything, drop the byte
            head_d      = tail_q;
            rsp_flush_d = 1'b1;
          end else if (req_i.rx_byte != CHAR_NUL) begin
            if (req_i.rx_byte == CHAR_CR) begin
              cr_cnt_d = cr_cnt_q + 1'b1;
            end
            if (req_i.rx_byte != CHAR_LF) begin
              head_d = head_nxt;
              mem_we = 1'b1;
            end
          end
          rsp_count_d = cr_cnt_d;
        end
        OP_READ: begin
          if (head_q == tail_q) begin
            rsp_valid_d = 1'b1;
            rsp_data_d  = '0;
            rsp_empty_d = 1'b1;
            rsp_flush_d = 1'b0;
            rsp_count_d = cr_cnt_q;
          end else begin
            tail_d  = tail_nxt;
            mem_re  = 1'b1;
            state_d = ST_READ;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= req_i.rx_byte;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[tail_nxt];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cr_cnt_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cr_cnt_q    <= cr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    rsp_data_q  <= rsp_data_d;
    rsp_empty_q <= rsp_empty_d;
    rsp_flush_q <= rsp_flush_d;
    rsp_count_q <= rsp_count_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.read_data      = rsp_data_q;
  assign rsp_o.was_empty      = rsp_empty_q;
  assign rsp_o.overflow_flush = rsp_flush_q;
  assign rsp_o.line_end_count = rsp_count_q;

endmodule

FILE: sim/uart_rx_line_ring_buffer_tb.sv
`timescale 1ns / 1ps
// Testbench for the serial-port receive ring buffer: random traffic checked against a mirror.
module uart_rx_line_ring_buffer_tb;
  import uart_rb_pkg::*;

  localparam int unsigned Depth      = DefaultBufferDepth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic             operation;
    logic [DataW-1:0] rx_byte;
  } rx_cmd_t;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic              was_empty;
    logic              overflow_flush;
    logic [CountW-1:0] line_end_count;
  } rx_reply_t;

  logic clk_i;
  logic rst_ni;

  uart_rb_req_if req_if ();
  uart_rb_rsp_if rsp_if ();

  uart_rx_line_ring_buffer #(
    .BUFFER_DEPTH(Depth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Commands waiting to be offered and replies still owed by the block
  rx_cmd_t   cmd_queue[$];
  rx_reply_t reply_queue[$];

  // Mirror of the ring state
  logic [DataW-1:0]  mirror_mem [Depth];
  int unsigned       mirror_head;
  int unsigned       mirror_tail;
  logic [CountW-1:0] mirror_crs;

  int unsigned cmds_planned;
  int unsigned cmds_sent;
  int unsigned replies_seen;
  int unsigned mismatches;
  int unsigned cycles;
  logic        cmd_taken;
  logic        rsp_hold;
  rx_cmd_t   next_cmd;
  rx_reply_t want;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned ring_advance(int unsigned idx);
    return (idx + 1 >= Depth) ? 0 : idx + 1;
  endfunction

  // One step of the ring: update the mirror and return the reply it owes
  function automatic rx_reply_t ring_step(logic op, logic [DataW-1:0] b);
    rx_reply_t   r;
    int unsigned nh;
    r = '0;
    if (op == OP_RECEIVE) begin
      nh = ring_advance(mirror_head);
      if (nh == mirror_tail) begin
        mirror_head = mirror_tail;
        r.overflow_flush = 1'b1;
      end else if (b != CHAR_NUL) begin
        if (b == CHAR_CR) mirror_crs = mirror_crs + 1'b1;
        if (b != CHAR_LF) begin
          mirror_head = nh;
          mirror_mem[nh] = b;
        end
      end
    end else begin
      if (mirror_head == mirror_tail) begin
        r.was_empty = 1'b1;
      end else begin
        mirror_tail = ring_advance(mirror_tail);
        r.read_data = mirror_mem[mirror_tail];
      end
    end
    r.line_end_count = mirror_crs;
    return r;
  endfunction

  task automatic queue_rx(logic [DataW-1:0] b);
    cmd_queue.push_back({OP_RECEIVE, b});
  endtask

  task automatic queue_rd();
    cmd_queue.push_back({OP_READ, DataW'($urandom_range(0, 255))});
  endtask

  // Mostly ordinary bytes, with the handled characters well represented
  function automatic logic [DataW-1:0] pick_byte();
    int unsigned k;
    k = $urandom_range(0, 15);
    case (k)
      0:       return CHAR_NUL;
      1, 2:    return CHAR_CR;
      3:       return CHAR_LF;
      default: return DataW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sender idles 22% then 63%, receiver the reverse, then neither idles at random
  function automatic int unsigned send_idle_pct();
    if (cmds_sent < cmds_planned / 3) return 22;
    if (cmds_sent < 2 * cmds_planned / 3) return 63;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (cmds_sent < cmds_planned / 3) return 63;
    if (cmds_sent < 2 * cmds_planned / 3) return 22;
    return 0;
  endfunction

  // Driver: a command stays on the channel until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || cmd_taken)) begin
      if (cmd_queue.size() > 0 && $urandom_range(1, 100) > send_idle_pct()) begin
        next_cmd = cmd_queue.pop_front();
        req_if.valid     <= 1'b1;
        req_if.operation <= next_cmd.operation;
        req_if.rx_byte   <= next_cmd.rx_byte;
        cmds_sent++;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    rsp_if.ready <= !rsp_hold && ($urandom_range(1, 100) > recv_idle_pct());
  end

  // Long hold-off on the reply side while commands keep coming
  initial begin
    rsp_hold = 1'b0;
    @(posedge rst_ni);
    while (cmds_sent < cmds_planned - 150) @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  // Monitor: predict on each taken command, check each taken reply
  always @(posedge clk_i) begin
    cmd_taken <= req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      reply_queue.push_back(ring_step(req_if.operation, req_if.rx_byte));
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      replies_seen++;
      if (reply_queue.size() == 0) begin
        note_mismatch($sformatf("reply %0d with nothing outstanding", replies_seen));
      end else begin
        want = reply_queue.pop_front();
        if (rsp_if.read_data !== want.read_data)
          note_mismatch($sformatf("reply %0d read_data %0h, want %0h", replies_seen,
                                  rsp_if.read_data, want.read_data));
        if (rsp_if.was_empty !== want.was_empty)
          note_mismatch($sformatf("reply %0d was_empty %0b, want %0b", replies_seen,
                                  rsp_if.was_empty, want.was_empty));
        if (rsp_if.overflow_flush !== want.overflow_flush)
          note_mismatch($sformatf("reply %0d overflow_flush %0b, want %0b", replies_seen,
                                  rsp_if.overflow_flush, want.overflow_flush));
        if (rsp_if.line_end_count !== want.line_end_count)
          note_mismatch($sformatf("reply %0d line_end_count %0d, want %0d", replies_seen,
                                  rsp_if.line_end_count, want.line_end_count));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned kind;
    int unsigned n;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_RECEIVE;
    req_if.rx_byte   = '0;
    rsp_if.ready     = 1'b0;
    cmd_taken        = 1'b0;
    cmds_sent        = 0;
    replies_seen     = 0;
    mismatches       = 0;
    cycles           = 0;
    mirror_head      = 0;
    mirror_tail      = 0;
    mirror_crs       = '0;
    for (int i = 0; i < Depth; i++) mirror_mem[i] = '0;

    // Directed: empty read, ignored and dropped characters, byte extremes, drain
    queue_rd();
    queue_rx(CHAR_NUL);
    queue_rx(CHAR_LF);
    queue_rx(CHAR_CR);
    queue_rx(8'hFF);
    queue_rx(8'h80);
    queue_rx(8'h7F);
    queue_rx(8'h01);
    queue_rx(8'hAA);
    queue_rx(8'h55);
    repeat (8) queue_rd();

    // Random bursts
    while (cmd_queue.size() < 1400) begin
      kind = $urandom_range(0, 3);
      case (kind)
        0: begin
          // fill near or past capacity so the flush can trigger, then drain part way or fully
          n = $urandom_range(20, 40);
          repeat (n) queue_rx(pick_byte());
          n = $urandom_range(0, 35);
          repeat (n) queue_rd();
        end
        1: begin
          // interleaved receives and reads
          n = $urandom_range(5, 30);
          repeat (n) begin
            if ($urandom_range(0, 1)) queue_rd();
            else queue_rx(pick_byte());
          end
        end
        2: begin
          // run of line ends to walk the counter through its wrap
          n = $urandom_range(10, 25);
          repeat (n) queue_rx(CHAR_CR);
          n = $urandom_range(5, 25);
          repeat (n) queue_rd();
        end
        default: begin
          // short text lines closed by CR LF, read back with a chance of over-reads
          n = $urandom_range(2, 12);
          repeat (n) queue_rx(DataW'($urandom_range(1, 255)));
          queue_rx(CHAR_CR);
          queue_rx(CHAR_LF);
          n = $urandom_range(n, n + 6);
          repeat (n) queue_rd();
        end
      endcase
    end
    cmds_planned = cmd_queue.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() > 0 || req_if.valid || reply_queue.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
